// File: src/psu_pkg.sv
// Shared types and constants for the priority semaphore unit.
// Used by psu_controller, psu_datapath and priority_semaphore_unit.
`timescale 1ns / 1ps
`default_nettype none

package psu_pkg;

  // Field widths of one command transaction and one result transaction.
  localparam int CMD_W       = 2;
  localparam int SEM_IDX_W   = 3;
  localparam int TASK_ID_W   = 4;
  localparam int PRIO_W      = 8;
  localparam int COUNT_W     = 8;
  localparam int STATUS_W    = 3;

  // Packing of the command tdata, lowest field first.
  localparam int SEM_LO      = 0;
  localparam int TASK_LO     = SEM_LO + SEM_IDX_W;
  localparam int PRIO_LO     = TASK_LO + TASK_ID_W;
  localparam int INITC_LO    = PRIO_LO + PRIO_W;
  localparam int IN_BITS     = INITC_LO + COUNT_W;
  localparam int IN_DATA_W   = ((IN_BITS + 7) / 8) * 8;
  localparam int IN_USER_W   = CMD_W;
  localparam int OUT_DATA_W  = 8;

  localparam int DEF_NUM_SEMS  = 8;
  localparam int DEF_NUM_TASKS = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_INIT_BIN = 2'd0,
    CMD_INIT_CNT = 2'd1,
    CMD_WAIT     = 2'd2,
    CMD_SIGNAL   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_BIN  = 2'd1,
    KIND_CNT  = 2'd2
  } sem_kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_QUEUED   = 3'd1,
    ST_RELEASED = 3'd2,
    ST_WOKE     = 3'd3,
    ST_UNINIT   = 3'd4,
    ST_ALREADY  = 3'd5,
    ST_OVER     = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_DROP,
    S_WALK,
    S_INS_HEAD,
    S_INS_LINK,
    S_DEQ,
    S_RESP
  } fsm_state_t;

  // One datapath operation per cycle, issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_LOOKUP,
    OP_DROP,
    OP_WALK,
    OP_INS_HEAD,
    OP_INS_LINK,
    OP_DEQ,
    OP_LOAD_OUT
  } dp_op_t;

  // What the lookup of a command decided to do next.
  typedef enum logic [2:0] {
    ACT_DONE,
    ACT_DROP,
    ACT_WALK,
    ACT_INSERT,
    ACT_DEQ
  } lookup_act_t;

  typedef struct packed {
    lookup_act_t act;
    logic        step_done;
    logic        need_link;
    logic        out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// File: src/priority_semaphore_unit.sv
// Top level of the priority semaphore unit: controller plus datapath.
// Depends on psu_pkg, psu_controller and psu_datapath.
//
//   Port group   Dir  Contents
//   s_*          in   command transaction: tuser = command, tdata = semaphore and task fields
//   m_*          out  result transaction: status, woken flag, woken task
//
// Wait with queueing: bounded by the priority walk over the task link memory, one
// link per cycle. Init of a semaphore with waiters: the walk that clears the wait
// flags. A signal that wakes a task passes S_LOOKUP, S_DEQ and S_RESP; a wait queued
// on an empty list passes S_LOOKUP, S_INS_HEAD and S_RESP; other commands S_LOOKUP, S_RESP.
// Reset clears the semaphore valid bits and the wait flags at once; no clearing pass.
// A held result in the output register stalls only the end of the next command.
`timescale 1ns / 1ps
`default_nettype none

module priority_semaphore_unit #(
  parameter int NUM_SEMS  = psu_pkg::DEF_NUM_SEMS,
  parameter int NUM_TASKS = psu_pkg::DEF_NUM_TASKS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // Fields from bit 0: sem_index, task_id, task_prio, initial_count, zero pad.
  input  logic [psu_pkg::IN_DATA_W-1:0]   s_tdata,
  // Fields from bit 0: command.
  input  logic [psu_pkg::IN_USER_W-1:0]   s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // Fields from bit 0: status, woken_valid, woken_task.
  output logic [psu_pkg::OUT_DATA_W-1:0]  m_tdata
);
  import psu_pkg::*;

  dp_op_t     op;
  dp_status_t stat;

  psu_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .op       (op)
  );

  psu_datapath #(
    .NUM_SEMS  (NUM_SEMS),
    .NUM_TASKS (NUM_TASKS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .op       (op),
    .stat     (stat),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // One command is in flight at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("new command accepted right after another");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    (op == OP_LOAD_OUT) |=> m_tvalid)
    else $error("loaded result not presented");

  // The woken flag goes with the woke status and with no other.
  a_woken_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[3] == (m_tdata[2:0] == ST_WOKE)))
    else $error("woken flag disagrees with status");

endmodule

`default_nettype wire

// File: src/psu_controller.sv
// Sequencing state machine of the priority semaphore unit.
// Depends on psu_pkg; drives one datapath operation per cycle.
`timescale 1ns / 1ps
`default_nettype none

module psu_controller (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  psu_pkg::dp_status_t    stat,
  output psu_pkg::dp_op_t        op
);
  import psu_pkg::*;

  fsm_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) state_next = S_LOOKUP;
      end
      S_LOOKUP: begin
        unique case (stat.act)
          ACT_DROP:   state_next = S_DROP;
          ACT_WALK:   state_next = S_WALK;
          ACT_INSERT: state_next = S_INS_HEAD;
          ACT_DEQ:    state_next = S_DEQ;
          default:    state_next = S_RESP;
        endcase
      end
      S_DROP: begin
        if (stat.step_done) state_next = S_RESP;
      end
      S_WALK: begin
        if (stat.step_done) state_next = S_INS_HEAD;
      end
      S_INS_HEAD: begin
        state_next = stat.need_link ? S_INS_LINK : S_RESP;
      end
      S_INS_LINK: state_next = S_RESP;
      S_DEQ:      state_next = S_RESP;
      S_RESP: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    op       = OP_NONE;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) op = OP_ACCEPT;
      end
      S_LOOKUP:   op = OP_LOOKUP;
      S_DROP:     op = OP_DROP;
      S_WALK:     op = OP_WALK;
      S_INS_HEAD: op = OP_INS_HEAD;
      S_INS_LINK: op = OP_INS_LINK;
      S_DEQ:      op = OP_DEQ;
      S_RESP: begin
        if (stat.out_free) op = OP_LOAD_OUT;
      end
      default:    op = OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

// File: src/psu_datapath.sv
// Semaphore table, per-task link and priority memories, wait flags and result register.
// Depends on psu_pkg; executes the operation chosen by psu_controller.
`timescale 1ns / 1ps
`default_nettype none

module psu_datapath #(
  parameter int NUM_SEMS  = psu_pkg::DEF_NUM_SEMS,
  parameter int NUM_TASKS = psu_pkg::DEF_NUM_TASKS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  psu_pkg::dp_op_t                 op,
  output psu_pkg::dp_status_t             stat,
  input  logic [psu_pkg::IN_DATA_W-1:0]   s_tdata,
  input  logic [psu_pkg::IN_USER_W-1:0]   s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [psu_pkg::OUT_DATA_W-1:0]  m_tdata
);
  import psu_pkg::*;

  localparam int SW  = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
  localparam int TIW = $clog2(NUM_TASKS);
  localparam int LW  = $clog2(NUM_TASKS + 1);
  localparam logic [LW-1:0] NO_TASK   = LW'(NUM_TASKS);
  localparam logic [LW-1:0] LAST_STEP = LW'(NUM_TASKS - 1);

  // Unpacked command fields.
  cmd_t                 cmd_in;
  logic [SEM_IDX_W-1:0] sem_in;
  logic [TASK_ID_W-1:0] task_in;
  logic [SW-1:0]        s_wrap;
  logic [TIW-1:0]       t_wrap;

  // Command held for the duration of the transaction.
  cmd_t                 cmd_q;
  logic [SW-1:0]        s_q;
  logic [TIW-1:0]       t_q;
  logic [PRIO_W-1:0]    prio_q;
  logic [COUNT_W-1:0]   initc_q;

  // Semaphore table.
  sem_kind_t            kind_mem  [NUM_SEMS];
  logic [COUNT_W-1:0]   count_mem [NUM_SEMS];
  logic [COUNT_W-1:0]   max_mem   [NUM_SEMS];
  logic [LW-1:0]        head_mem  [NUM_SEMS];
  logic [NUM_SEMS-1:0]  sem_valid;
  sem_kind_t            kind_rd;
  logic [COUNT_W-1:0]   count_rd;
  logic [COUNT_W-1:0]   max_rd;
  logic [LW-1:0]        head_rd;
  sem_kind_t            kind_e;
  logic [COUNT_W-1:0]   count_e;
  logic [COUNT_W-1:0]   max_e;
  logic [LW-1:0]        head_e;

  logic                 sem_we;
  sem_kind_t            sem_wkind;
  logic [COUNT_W-1:0]   sem_wcount;
  logic [COUNT_W-1:0]   sem_wmax;
  logic [LW-1:0]        sem_whead;

  // Per-task tables.
  logic [LW-1:0]        link_mem [NUM_TASKS];
  logic [PRIO_W-1:0]    prio_mem [NUM_TASKS];
  logic [LW-1:0]        link_rd;
  logic [PRIO_W-1:0]    prio_rd;
  logic [TIW-1:0]       task_raddr;
  logic                 link_we;
  logic [TIW-1:0]       link_waddr;
  logic [LW-1:0]        link_wdata;
  logic                 prio_we;
  logic [NUM_TASKS-1:0] waiting;

  // List walk registers.
  logic [LW-1:0]        cur;
  logic [LW-1:0]        prev;
  logic [LW-1:0]        steps;
  logic [LW-1:0]        nxt;
  logic                 walk_end;

  status_t              lk_status;
  status_t              res_status;
  logic                 res_wv;
  logic [TASK_ID_W-1:0] res_wt;

  logic                 kind_ok;
  logic                 empty;
  logic                 over;
  sem_kind_t            init_kind;
  logic [COUNT_W-1:0]   init_count;

  assign cmd_in  = cmd_t'(s_tuser);
  assign sem_in  = s_tdata[SEM_LO +: SEM_IDX_W];
  assign task_in = s_tdata[TASK_LO +: TASK_ID_W];

  // Index wrap by a small constant table.
  always_comb begin
    s_wrap = '0;
    for (int i = 0; i < (1 << SEM_IDX_W); i++) begin
      if (sem_in == SEM_IDX_W'(i)) s_wrap = SW'(i % NUM_SEMS);
    end
  end

  always_comb begin
    t_wrap = '0;
    for (int i = 0; i < (1 << TASK_ID_W); i++) begin
      if (task_in == TASK_ID_W'(i)) t_wrap = TIW'(i % NUM_TASKS);
    end
  end

  always_ff @(posedge clk) begin
    if (op == OP_ACCEPT) begin
      cmd_q   <= cmd_in;
      s_q     <= s_wrap;
      t_q     <= t_wrap;
      prio_q  <= s_tdata[PRIO_LO +: PRIO_W];
      initc_q <= s_tdata[INITC_LO +: COUNT_W];
    end
  end

  // Semaphore table: read once per transaction, written at most once per cycle.
  always_ff @(posedge clk) begin
    if (sem_we) begin
      kind_mem[s_q]  <= sem_wkind;
      count_mem[s_q] <= sem_wcount;
      max_mem[s_q]   <= sem_wmax;
      head_mem[s_q]  <= sem_whead;
    end
    if (op == OP_ACCEPT) begin
      kind_rd  <= kind_mem[s_wrap];
      count_rd <= count_mem[s_wrap];
      max_rd   <= max_mem[s_wrap];
      head_rd  <= head_mem[s_wrap];
    end
  end

  // An entry never written since reset reads as uninitialized with an empty queue.
  assign kind_e  = sem_valid[s_q] ? kind_rd  : KIND_NONE;
  assign count_e = sem_valid[s_q] ? count_rd : '0;
  assign max_e   = sem_valid[s_q] ? max_rd   : '0;
  assign head_e  = sem_valid[s_q] ? head_rd  : NO_TASK;

  // The walk reads the entry that the previous read pointed to.
  assign task_raddr = (op == OP_LOOKUP) ? head_e[TIW-1:0] : link_rd[TIW-1:0];

  always_ff @(posedge clk) begin
    if (link_we) link_mem[link_waddr] <= link_wdata;
    if (prio_we) prio_mem[t_q] <= prio_q;
    link_rd <= link_mem[task_raddr];
    prio_rd <= prio_mem[task_raddr];
  end

  assign kind_ok    = (kind_e == KIND_BIN) || (kind_e == KIND_CNT);
  assign empty      = (head_e >= NO_TASK);
  assign over       = (kind_e == KIND_BIN) ? (count_e != '0)
                                           : (empty && (count_e == max_e));
  assign init_kind  = (cmd_q == CMD_INIT_BIN) ? KIND_BIN : KIND_CNT;
  assign init_count = (cmd_q == CMD_INIT_BIN) ? COUNT_W'(1) : initc_q;
  assign nxt        = link_rd;
  assign walk_end   = (steps == LAST_STEP) || (nxt >= NO_TASK);

  always_comb begin
    stat.act       = ACT_DONE;
    stat.step_done = 1'b0;
    stat.need_link = (prev < NO_TASK);
    stat.out_free  = !m_tvalid || m_tready;
    lk_status      = ST_OK;
    sem_we         = 1'b0;
    sem_wkind      = kind_e;
    sem_wcount     = count_e;
    sem_wmax       = max_e;
    sem_whead      = head_e;
    link_we        = 1'b0;
    link_waddr     = t_q;
    link_wdata     = cur;
    prio_we        = 1'b0;
    unique case (op)
      OP_LOOKUP: begin
        unique case (cmd_q) inside
          CMD_INIT_BIN, CMD_INIT_CNT: begin
            if (!empty) begin
              stat.act = ACT_DROP;
            end else begin
              sem_we     = 1'b1;
              sem_wkind  = init_kind;
              sem_wcount = init_count;
              sem_wmax   = init_count;
              sem_whead  = NO_TASK;
            end
          end
          CMD_WAIT: begin
            if (!kind_ok) begin
              lk_status = ST_UNINIT;
            end else if (count_e != '0) begin
              sem_we     = 1'b1;
              sem_wcount = count_e - COUNT_W'(1);
            end else if (waiting[t_q]) begin
              lk_status = ST_ALREADY;
            end else begin
              lk_status = ST_QUEUED;
              stat.act  = empty ? ACT_INSERT : ACT_WALK;
            end
          end
          default: begin
            if (!kind_ok) begin
              lk_status = ST_UNINIT;
            end else if (over) begin
              lk_status = ST_OVER;
            end else if (!empty) begin
              lk_status = ST_WOKE;
              stat.act  = ACT_DEQ;
            end else begin
              lk_status  = ST_RELEASED;
              sem_we     = 1'b1;
              sem_wcount = (kind_e == KIND_BIN) ? COUNT_W'(1) : count_e + COUNT_W'(1);
            end
          end
        endcase
      end
      OP_DROP: begin
        stat.step_done = walk_end;
        if (walk_end) begin
          sem_we     = 1'b1;
          sem_wkind  = init_kind;
          sem_wcount = init_count;
          sem_wmax   = init_count;
          sem_whead  = NO_TASK;
        end
      end
      OP_WALK: begin
        stat.step_done = (prio_rd < prio_q) || walk_end;
      end
      OP_INS_HEAD: begin
        link_we = 1'b1;
        prio_we = 1'b1;
        if (prev >= NO_TASK) begin
          sem_we    = 1'b1;
          sem_whead = LW'(t_q);
        end
      end
      OP_INS_LINK: begin
        link_we    = 1'b1;
        link_waddr = prev[TIW-1:0];
        link_wdata = LW'(t_q);
      end
      OP_DEQ: begin
        sem_we    = 1'b1;
        sem_whead = (nxt >= NO_TASK) ? NO_TASK : nxt;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_LOOKUP: begin
        cur        <= head_e;
        prev       <= NO_TASK;
        steps      <= '0;
        res_status <= lk_status;
        res_wv     <= 1'b0;
        res_wt     <= '0;
      end
      OP_DROP: begin
        cur   <= nxt;
        steps <= steps + LW'(1);
      end
      OP_WALK: begin
        // Stay on the first waiter of lower priority; otherwise move one link on.
        if (!(prio_rd < prio_q)) begin
          prev  <= cur;
          cur   <= (nxt >= NO_TASK) ? NO_TASK : nxt;
          steps <= steps + LW'(1);
        end
      end
      OP_DEQ: begin
        res_wv <= 1'b1;
        res_wt <= TASK_ID_W'(cur);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      waiting   <= '0;
      sem_valid <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (sem_we) sem_valid[s_q] <= 1'b1;
      case (op)
        OP_DROP:     waiting[cur[TIW-1:0]] <= 1'b0;
        OP_INS_HEAD: waiting[t_q] <= 1'b1;
        OP_DEQ:      waiting[cur[TIW-1:0]] <= 1'b0;
        default: ;
      endcase
      if (op == OP_LOAD_OUT) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (op == OP_LOAD_OUT) m_tdata <= {res_wt, res_wv, res_status};
  end

endmodule

`default_nettype wire
